// ===== sv/p1tfc_pkg.sv =====
// Package for the P1 telegram framer with CRC check.
// Holds beat structs, opcode, status, phase and register codes, and CRC constants.
// No dependencies.
package p1tfc_pkg;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_e;

  // Framer phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HUNT  = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_FIELD = 4'b1000
  } phase_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_MAX_LEN = 2'd1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] TimeoutReset = 16'd15000;
  localparam logic [11:0] MaxLenReset  = 12'd1500;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'h0000;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Input beat
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic [11:0] telegram_length;
  } out_t;

endpackage

// ===== sv/p1_telegram_framer_crc_check.sv =====
// Top level of the P1 telegram framer with CRC-16 check.
// Depends on p1tfc_pkg, p1tfc_core (with p1tfc_crc) and p1tfc_out_buf.
//
//  channel  | direction | handshake               | beat
//  ---------+-----------+-------------------------+-----------------------------
//  input    | in        | in_valid_i / in_stall_o | op, rx_byte
//  result   | out       | out_valid_o/out_stall_i | status, crcs, telegram_length
//  config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while the result buffer has room; a beat is registered,
// processed once the buffer has room, and its result (if any) is visible in the cycle after that.
// The rate is set by the combinational byte CRC update and phase machine.
// A two-entry result buffer absorbs output stalls; input stalls only when it is full.
// Reset (async, active low) sets idle phase and the register defaults; no clearing pass.
module p1_telegram_framer_crc_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  p1tfc_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output p1tfc_pkg::out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [p1tfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [p1tfc_pkg::CfgDataW-1:0] cfg_data_i
);

  logic            room;
  logic            push;
  p1tfc_pkg::out_t result;

  p1tfc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .room_i      (room),
    .push_o      (push),
    .result_o    (result),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  p1tfc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/p1tfc_crc.sv =====
// Byte-wide reflected CRC-16 update (poly 0xA001).
// Depends on p1tfc_pkg.
module p1tfc_crc (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  // Eight bit steps, LSB first
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ p1tfc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ===== sv/p1tfc_core.sv =====
// Framer core: input register, phase machine, counters and CRC check.
// Depends on p1tfc_pkg and p1tfc_crc.
module p1tfc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  p1tfc_pkg::in_t                in_data_i,
  input  logic                          room_i,
  output logic                          push_o,
  output p1tfc_pkg::out_t               result_o,
  input  logic                          cfg_we_i,
  input  logic [p1tfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [p1tfc_pkg::CfgDataW-1:0] cfg_data_i
);

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  logic              in_vld_q;
  p1tfc_pkg::in_t    in_q;
  logic              go;

  logic [15:0]       timeout_q;
  logic [11:0]       max_len_q;

  p1tfc_pkg::phase_e phase_q, phase_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       tick_q, tick_d;
  logic [11:0]       cnt_q, cnt_d;
  logic [15:0]       acc_q, acc_d;
  logic [2:0]        dig_q, dig_d;
  logic              bad_q, bad_d;

  logic [15:0]       crc_in, crc_next;
  logic [4:0]        hv;
  logic [11:0]       cnt_inc;
  logic [15:0]       tick_inc;
  logic              full;

  // Input register
  assign go         = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= p1tfc_pkg::TimeoutReset;
      max_len_q <= p1tfc_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        p1tfc_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        p1tfc_pkg::CFG_MAX_LEN: max_len_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // CRC update; the opening slash starts from the init value
  assign crc_in = (phase_q == p1tfc_pkg::PH_HUNT) ? p1tfc_pkg::CrcInit : crc_q;

  p1tfc_crc u_crc (
    .crc_i  (crc_in),
    .data_i (in_q.rx_byte),
    .crc_o  (crc_next)
  );

  assign hv       = hex_val(in_q.rx_byte);
  assign cnt_inc  = cnt_q + 12'd1;
  assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign full     = cnt_q >= max_len_q;

  // Phase machine and result
  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    tick_d   = tick_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    dig_d    = dig_q;
    bad_d    = bad_q;
    push_o   = 1'b0;
    result_o.status          = p1tfc_pkg::ST_OK;
    result_o.computed_crc    = crc_q;
    result_o.received_crc    = acc_q;
    result_o.telegram_length = cnt_q;

    if (go) begin
      if (in_q.op == p1tfc_pkg::OP_START) begin
        phase_d = p1tfc_pkg::PH_HUNT;
        crc_d   = p1tfc_pkg::CrcInit;
        tick_d  = '0;
        cnt_d   = '0;
        acc_d   = '0;
        dig_d   = '0;
        bad_d   = 1'b0;
      end else if (in_q.op == p1tfc_pkg::OP_TICK && phase_q != p1tfc_pkg::PH_IDLE) begin
        tick_d = tick_inc;
        if (tick_inc >= timeout_q) begin
          push_o          = 1'b1;
          result_o.status = p1tfc_pkg::ST_TIMEOUT;
          phase_d         = p1tfc_pkg::PH_IDLE;
        end
      end else if (in_q.op == p1tfc_pkg::OP_BYTE) begin
        unique case (phase_q)
          p1tfc_pkg::PH_HUNT: begin
            if (in_q.rx_byte == p1tfc_pkg::ChSlash) begin
              if (full) begin
                push_o          = 1'b1;
                result_o.status = p1tfc_pkg::ST_TOO_LONG;
                phase_d         = p1tfc_pkg::PH_IDLE;
              end else begin
                cnt_d   = cnt_inc;
                crc_d   = crc_next;
                phase_d = p1tfc_pkg::PH_BODY;
              end
            end
          end
          p1tfc_pkg::PH_BODY: begin
            if (full) begin
              push_o          = 1'b1;
              result_o.status = p1tfc_pkg::ST_TOO_LONG;
              phase_d         = p1tfc_pkg::PH_IDLE;
            end else begin
              cnt_d = cnt_inc;
              crc_d = crc_next;
              if (in_q.rx_byte == p1tfc_pkg::ChBang) begin
                phase_d = p1tfc_pkg::PH_FIELD;
              end
            end
          end
          p1tfc_pkg::PH_FIELD: begin
            if (full) begin
              push_o          = 1'b1;
              result_o.status = p1tfc_pkg::ST_TOO_LONG;
              phase_d         = p1tfc_pkg::PH_IDLE;
            end else begin
              cnt_d = cnt_inc;
              if (in_q.rx_byte == p1tfc_pkg::ChLf) begin
                // End of telegram: judge the CRC field
                push_o                   = 1'b1;
                phase_d                  = p1tfc_pkg::PH_IDLE;
                result_o.telegram_length = cnt_inc;
                if (bad_q || dig_q < 3'd4) begin
                  result_o.status = p1tfc_pkg::ST_MALFORMED;
                end else if (acc_q == crc_q) begin
                  result_o.status = p1tfc_pkg::ST_OK;
                end else begin
                  result_o.status = p1tfc_pkg::ST_MISMATCH;
                end
              end else if (dig_q < 3'd4) begin
                dig_d = dig_q + 3'd1;
                if (hv[4]) begin
                  acc_d = {acc_q[11:0], hv[3:0]};
                end else begin
                  bad_d = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= p1tfc_pkg::PH_IDLE;
      crc_q   <= p1tfc_pkg::CrcInit;
      tick_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      dig_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      tick_q  <= tick_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
      bad_q   <= bad_d;
    end
  end

  // Checks
  a_push_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (phase_q != p1tfc_pkg::PH_IDLE && go))
    else $error("result from idle phase");

  a_push_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (phase_q == p1tfc_pkg::PH_IDLE))
    else $error("phase not idle after result");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && in_q.op == p1tfc_pkg::OP_START) |=>
      (phase_q == p1tfc_pkg::PH_HUNT && cnt_q == 12'd0 && dig_q == 3'd0 && !bad_q))
    else $error("start did not clear state");

  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_q != $past(dig_q)) |-> (dig_q <= 3'd4))
    else $error("digit count past four");

endmodule

// ===== sv/p1tfc_out_buf.sv =====
// Two-entry result buffer that decouples the core from output stalls.
// Depends on p1tfc_pkg.
module p1tfc_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  p1tfc_pkg::out_t data_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output p1tfc_pkg::out_t out_data_o
);

  p1tfc_pkg::out_t buf_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            pop;

  assign room_o      = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = buf_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push into full result buffer");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd3) && ((cnt_q == 2'd0) == (wr_q == rd_q) || cnt_q == 2'd2))
    else $error("result buffer count out of step with pointers");

endmodule

// ===== verif/tb_p1_telegram_framer_crc_check.sv =====
`timescale 1ns / 100ps
// Testbench for p1_telegram_framer_crc_check: drives serial bytes, ticks and start requests,
// predicts each telegram result and checks it. Depends on p1tfc_pkg and the block's RTL only.
module tb_p1_telegram_framer_crc_check;
  import p1tfc_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = 6;

  // Telegram predictor and store of expected results
  class telegram_checker;
    logic [15:0] timeout_ticks = TimeoutReset;
    logic [11:0] max_length = MaxLenReset;
    phase_e phase = PH_IDLE;
    logic [15:0] crc = CrcInit;
    logic [15:0] ticks = '0;
    logic [15:0] acc = '0;
    logic [11:0] count = '0;
    int unsigned digits = 0;
    bit malformed = 1'b0;
    out_t expected_frames[$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned status_seen[5];

    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
    endfunction

    static function int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
    endfunction

    function void set_register(cfg_idx_e idx, logic [15:0] value);
      if (idx == CFG_TIMEOUT) timeout_ticks = value;
      else if (idx == CFG_MAX_LEN) max_length = value[11:0];
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    function void close_telegram(status_e st);
      expected_frames.push_back(out_t'{status: st, computed_crc: crc,
                                       received_crc: acc, telegram_length: count});
      phase = PH_IDLE;
    endfunction

    // One accepted input beat
    function void note_beat(in_t beat);
      op_e op;
      logic [7:0] b;
      int v;
      op = op_e'(beat.op);
      b = beat.rx_byte;
      if (op == OP_START) begin
        crc = CrcInit;
        ticks = '0;
        count = '0;
        acc = '0;
        digits = 0;
        malformed = 1'b0;
        phase = PH_HUNT;
        return;
      end
      if (op == OP_NONE || phase == PH_IDLE) return;
      if (op == OP_TICK) begin
        if (ticks != 16'hFFFF) ticks++;
        if (ticks >= timeout_ticks) close_telegram(ST_TIMEOUT);
        return;
      end
      // received byte; bytes before the slash are dropped
      if (phase == PH_HUNT && b != ChSlash) return;
      if (count >= max_length) begin
        close_telegram(ST_TOO_LONG);
        return;
      end
      count++;
      if (phase == PH_HUNT) begin
        crc = crc16_step(CrcInit, b);
        phase = PH_BODY;
      end else if (phase == PH_BODY) begin
        crc = crc16_step(crc, b);
        if (b == ChBang) phase = PH_FIELD;
      end else if (b == ChLf) begin
        if (malformed || digits < 4) close_telegram(ST_MALFORMED);
        else if (acc == crc) close_telegram(ST_OK);
        else close_telegram(ST_MISMATCH);
      end else if (digits < 4) begin
        // only the first four bytes after the bang are digit positions
        v = hex_value(b);
        if (v < 0) malformed = 1'b1;
        else acc = {acc[11:0], 4'(v)};
        digits++;
      end
    endfunction

    // One accepted result beat against the oldest expectation
    function void check_frame(out_t got);
      out_t want;
      if (expected_frames.size() == 0) begin
        $error("unexpected result beat: status %0d crc %h/%h length %0d", got.status,
               got.computed_crc, got.received_crc, got.telegram_length);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      checked++;
      if (want.status < 5) status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.computed_crc !== want.computed_crc) begin
        $error("computed_crc: expected %h, got %h", want.computed_crc, got.computed_crc);
        errors++;
      end
      if (got.received_crc !== want.received_crc) begin
        $error("received_crc: expected %h, got %h", want.received_crc, got.received_crc);
        errors++;
      end
      if (got.telegram_length !== want.telegram_length) begin
        $error("telegram_length: expected %0d, got %0d", want.telegram_length,
               got.telegram_length);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  telegram_checker sb = new();
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;

  p1_telegram_framer_crc_check i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side stalls at random, except in the steady stretch
  always @(posedge clk_i) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 19);
  end

  // Beat monitor: values read here are the ones before this edge's updates
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_frame(out_data);
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("no beat moved for %0d cycles", QuietLimit);
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'("0") + 8'(n);
    return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  // Drive one beat, with an occasional gap ahead of it, and wait until accepted
  task automatic send_item(op_e code, logic [7:0] data);
    if (!steady && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= in_t'{op: code, rx_byte: data};
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic write_register(cfg_idx_e idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    sb.set_register(idx, value);
  endtask

  // Let the block go idle, then load both registers
  task automatic reconfigure(logic [15:0] timeout, logic [11:0] max_len);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    write_register(CFG_TIMEOUT, timeout);
    write_register(CFG_MAX_LEN, {4'h0, max_len});
    cfg_we <= 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  // Short fixed sequences at the reset register values
  task automatic directed();
    logic [15:0] c;
    // anything but a start request is ignored while idle
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_NONE, 8'h00);
    // good telegram with a leading stray byte and mixed-case digits
    c = telegram_checker::crc16_step(CrcInit, ChSlash);
    c = telegram_checker::crc16_step(c, "A");
    c = telegram_checker::crc16_step(c, ChBang);
    send_item(OP_START, 8'h00);
    send_text("x/A!");
    for (int i = 0; i < 4; i++) send_item(OP_BYTE, hex_char(4'(c >> (12 - 4 * i)), i[0]));
    send_item(OP_BYTE, 8'h0D);
    send_item(OP_BYTE, ChLf);
    // line feed before any digit
    send_item(OP_START, 8'hFF);
    send_text("/!");
    send_item(OP_BYTE, ChLf);
    // non-hex digit in the crc field
    send_item(OP_START, 8'h00);
    send_text("/!zfF0");
    send_item(OP_BYTE, ChLf);
  endtask

  // One telegram with random content; some are damaged on purpose
  task automatic run_telegram(int unsigned max_body, int unsigned tick_pct);
    logic [15:0] c;
    logic [15:0] field;
    logic [7:0] b;
    int unsigned kind;
    int unsigned digits;
    int unsigned bad_pos;
    send_item(OP_START, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom_range(0, 255));
      send_item(OP_BYTE, (b == ChSlash) ? 8'h20 : b);
    end
    send_item(OP_BYTE, ChSlash);
    c = telegram_checker::crc16_step(CrcInit, ChSlash);
    repeat ($urandom_range(0, max_body)) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 199) == 0) begin
        // restart in the middle of a telegram
        send_item(OP_START, 8'($urandom_range(0, 255)));
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == ChBang) b = 8'h20;
        c = telegram_checker::crc16_step(c, b);
        send_item(OP_BYTE, b);
      end
    end
    send_item(OP_BYTE, ChBang);
    c = telegram_checker::crc16_step(c, ChBang);
    // crc field: mostly right, sometimes wrong, bad, short or padded
    kind = $urandom_range(0, 9);
    field = c;
    digits = 4;
    bad_pos = 4;
    if (kind == 6) field = c ^ (16'h0001 << $urandom_range(0, 15));
    if (kind == 7) bad_pos = $urandom_range(0, 3);
    if (kind == 8) digits = $urandom_range(0, 3);
    for (int i = 0; i < digits; i++) begin
      if (i == bad_pos) b = 8'($urandom_range(8'h67, 8'h7A));
      else b = hex_char(4'(field >> (12 - 4 * i)), 1'($urandom_range(0, 1)));
      send_item(OP_BYTE, b);
    end
    if (kind == 9) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 255));
        send_item(OP_BYTE, (b == ChLf) ? 8'h0D : b);
      end
    end
    if ($urandom_range(0, 1) == 1) send_item(OP_BYTE, 8'h0D);
    send_item(OP_BYTE, ChLf);
  endtask

  task automatic run_phase(int unsigned n_items, int unsigned max_body, int unsigned tick_pct);
    int unsigned stop;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any op, any byte
        repeat ($urandom_range(1, 4))
          send_item(op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        run_telegram(max_body, tick_pct);
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    directed();
    run_phase(100, 24, 5);
    // tightest limits: first tick or seventeenth byte ends the telegram
    reconfigure(16'd1, 12'd16);
    run_phase(100, 24, 5);
    // widest limits, no idling on either side
    steady = 1'b1;
    reconfigure(16'hFFFF, 12'd4095);
    run_phase(150, 60, 5);
    steady = 1'b0;
    // zero timeout: the first tick after a start request times out
    reconfigure(16'd0, 12'd40);
    run_phase(50, 24, 5);
    while (items_sent < 700) begin
      reconfigure(16'($urandom_range(1, 40)), 12'($urandom_range(16, 80)));
      run_phase(100, 24, 10);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d input beats, checked %0d telegram results", items_sent, sb.checked);
    $display("ok %0d, mismatch %0d, malformed %0d, too long %0d, timeout %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_MISMATCH], sb.status_seen[ST_MALFORMED],
             sb.status_seen[ST_TOO_LONG], sb.status_seen[ST_TIMEOUT]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
